FILE: design/bbl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bbl_pkg
// Shared types and constants for the horizontal box blur line filter.
// ---------------------------------------------------------------------------
package bbl_pkg;

    localparam int CHAN_W    = 8;
    localparam int NCH       = 3;
    localparam int RADIUS_W  = 6;
    localparam int DIV_W     = RADIUS_W + 1;
    localparam int SUM_W     = 15;
    localparam int CNT_W     = 7;
    localparam int DIV_CNT_W = 4;

    localparam logic [RADIUS_W-1:0]  RADIUS_RESET = 6'd25;
    localparam logic [CNT_W-1:0]     RESULT_CAP   = 7'd64;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST     = 4'(SUM_W - 1);

    typedef logic [CHAN_W-1:0] t_chan;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_pixel;

    typedef struct packed {
        logic accept;
        logic setup_walk;
        logic walk_step;
        logic div_start;
        logic div_step;
        logic load_out;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic walk_done;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

FILE: design/bbl_pix_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bbl_pix_in_if
// Incoming pixel channel: valid/ready handshake with RGB and line end flag.
// ---------------------------------------------------------------------------
interface bbl_pix_in_if import bbl_pkg::*; ();

    logic  valid;
    logic  ready;
    t_chan red_in;
    t_chan green_in;
    t_chan blue_in;
    logic  line_end_in;

    modport source (
        output valid, red_in, green_in, blue_in, line_end_in,
        input  ready
    );

    modport sink (
        input  valid, red_in, green_in, blue_in, line_end_in,
        output ready
    );

endinterface

FILE: design/bbl_pix_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bbl_pix_out_if
// Blurred pixel channel: valid/ready handshake with RGB and line end flag.
// ---------------------------------------------------------------------------
interface bbl_pix_out_if import bbl_pkg::*; ();

    logic  valid;
    logic  ready;
    t_chan red_out;
    t_chan green_out;
    t_chan blue_out;
    logic  line_end_out;

    modport source (
        output valid, red_out, green_out, blue_out, line_end_out,
        input  ready
    );

    modport sink (
        input  valid, red_out, green_out, blue_out, line_end_out,
        output ready
    );

endinterface

FILE: design/bbl_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bbl_ctrl
// Sequencer: accepts a pixel, then per due result walks the window, divides
// and hands the result to the output register.
// ---------------------------------------------------------------------------
module bbl_ctrl import bbl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DLOAD = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.emit) begin
                    o_cmd.setup_walk = 1'b1;
                    n_state          = S_WALK;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_done) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DLOAD;
            end
            S_DLOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/bbl_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bbl_datapath
// Pixel ring, line positions, window accumulator, radix-2 dividers and the
// output register.
// ---------------------------------------------------------------------------
module bbl_datapath import bbl_pkg::*; #(
    parameter int RING_DEPTH      = 128,
    parameter int MAX_LINE_LENGTH = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [RADIUS_W-1:0] i_cfg_wdata,
    input  t_pixel              i_pix,
    input  logic                i_pix_end,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_res_ready,
    output logic                o_res_valid,
    output t_pixel              o_res,
    output logic                o_res_end
);

    localparam int POS_W = $clog2(MAX_LINE_LENGTH + 1);
    localparam int SL_W  = $clog2(RING_DEPTH);
    localparam int WW    = ((POS_W > RADIUS_W + 1) ? POS_W : RADIUS_W + 1) + 2;

    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MAX_LINE_LENGTH - 1);
    localparam logic [SL_W-1:0]  SLOT_LAST = SL_W'(RING_DEPTH - 1);

    t_pixel r_ring [RING_DEPTH];

    logic [RADIUS_W-1:0]    r_radius;
    logic [POS_W-1:0]       r_in_pos;
    logic [SL_W-1:0]        r_in_slot;
    logic [POS_W-1:0]       r_out_pos;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_last;
    t_pixel                 r_first;

    logic signed [WW-1:0]   r_w;
    logic signed [WW-1:0]   r_lo;
    logic signed [WW-1:0]   r_hi;
    logic [SL_W-1:0]        r_slot;
    t_pixel                 r_rd_data;
    logic                   r_add_pend;
    logic                   r_add_first;

    logic [SUM_W-1:0]       r_sum [NCH];
    logic [SUM_W-1:0]       r_dvd [NCH];
    logic [DIV_W-1:0]       r_rem [NCH];
    logic [DIV_CNT_W-1:0]   r_div_cnt;

    logic                   r_out_vld;
    t_pixel                 r_out;
    logic                   r_out_end;

    logic signed [WW-1:0]   w_x;
    logic signed [WW-1:0]   w_p;
    logic signed [WW-1:0]   w_r;
    logic signed [WW-1:0]   w_hi;
    logic signed [WW-1:0]   w_lo;
    logic [DIV_W-1:0]       w_div;
    t_pixel                 w_add_px;
    t_chan                  w_add_ch [NCH];
    logic [SUM_W-1:0]       n_dvd [NCH];
    logic [DIV_W-1:0]       n_rem [NCH];
    logic [DIV_W:0]         w_trial [NCH];
    logic                   n_last;

    assign w_x   = $signed(WW'(r_out_pos));
    assign w_p   = $signed(WW'(r_in_pos));
    assign w_r   = $signed(WW'(r_radius));
    assign w_hi  = w_x + w_r;
    assign w_lo  = w_x - w_r;
    assign w_div = {r_radius, 1'b1};

    assign n_last = i_pix_end || (r_in_pos >= POS_LAST);

    assign o_status.emit      = (w_x <= w_p) && (r_last || (w_hi <= w_p))
                                && (r_cnt < RESULT_CAP);
    assign o_status.walk_done = (r_w == r_lo);
    assign o_status.div_done  = (r_div_cnt == '0);
    assign o_status.out_free  = !r_out_vld || i_res_ready;

    assign w_add_px    = r_add_first ? r_first : r_rd_data;
    assign w_add_ch[0] = w_add_px.red;
    assign w_add_ch[1] = w_add_px.green;
    assign w_add_ch[2] = w_add_px.blue;

    // one quotient bit per step, quotient shifts into the dividend register
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_trial[c] = {r_rem[c], r_dvd[c][SUM_W-1]};
            if (w_trial[c] >= {1'b0, w_div}) begin
                n_rem[c] = DIV_W'(w_trial[c] - {1'b0, w_div});
                n_dvd[c] = {r_dvd[c][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[c] = w_trial[c][DIV_W-1:0];
                n_dvd[c] = {r_dvd[c][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ring[r_in_slot] <= i_pix;
        end
        r_rd_data <= r_ring[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RADIUS_RESET;
            r_in_pos   <= '0;
            r_in_slot  <= '0;
            r_out_pos  <= '0;
            r_cnt      <= '0;
            r_last     <= 1'b0;
            r_add_pend <= 1'b0;
            r_div_cnt  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_last <= n_last;
                r_cnt  <= '0;
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_in_pos  <= '0;
                    r_in_slot <= '0;
                    r_out_pos <= '0;
                end else begin
                    r_in_pos  <= r_in_pos + POS_W'(1);
                    r_in_slot <= (r_in_slot == SLOT_LAST) ? '0 : r_in_slot + SL_W'(1);
                end
            end
            r_add_pend <= i_cmd.walk_step && (r_w <= r_hi);
            if (i_cmd.div_start) begin
                r_div_cnt <= DIV_LAST;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_pos <= r_out_pos + POS_W'(1);
                r_cnt     <= r_cnt + CNT_W'(1);
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (r_in_pos == '0)) begin
            r_first <= i_pix;
        end
        // walk runs from max(p, x+r) down to x-r; slot tracks min(w, p)
        if (i_cmd.setup_walk) begin
            r_w    <= (w_hi > w_p) ? w_hi : w_p;
            r_hi   <= w_hi;
            r_lo   <= w_lo;
            r_slot <= r_in_slot;
        end else if (i_cmd.walk_step) begin
            r_w <= r_w - WW'(1);
            if (r_w <= w_p) begin
                r_slot <= (r_slot == '0) ? SLOT_LAST : r_slot - SL_W'(1);
            end
        end
        if (i_cmd.walk_step) begin
            r_add_first <= (r_w < 0);
        end
        for (int c = 0; c < NCH; c++) begin
            if (i_cmd.setup_walk) begin
                r_sum[c] <= '0;
            end else if (r_add_pend) begin
                r_sum[c] <= r_sum[c] + SUM_W'(w_add_ch[c]);
            end
            if (i_cmd.div_start) begin
                r_dvd[c] <= r_sum[c];
                r_rem[c] <= '0;
            end else if (i_cmd.div_step) begin
                r_dvd[c] <= n_dvd[c];
                r_rem[c] <= n_rem[c];
            end
        end
        if (i_cmd.load_out) begin
            r_out.red   <= r_dvd[0][CHAN_W-1:0];
            r_out.green <= r_dvd[1][CHAN_W-1:0];
            r_out.blue  <= r_dvd[2][CHAN_W-1:0];
            r_out_end   <= r_last && (r_out_pos == r_in_pos);
        end
    end

    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;
    assign o_res_end   = r_out_end;

endmodule

FILE: design/box_blur_line_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_blur_line_filter
// Horizontal box blur over a line of RGB pixels with clamped line ends.
// Per result, the window is walked over one ring read port, then a 15-step
// divider runs; an output stall holds the result back. One pixel in flight;
// its results reach the output register before the next transfer is taken.
// Synchronous active-low reset: radius 25, positions zero, ring not cleared.
// ---------------------------------------------------------------------------
module box_blur_line_filter import bbl_pkg::*; #(
    parameter int RING_DEPTH      = 128,
    parameter int MAX_LINE_LENGTH = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [RADIUS_W-1:0] i_cfg_wdata,
    bbl_pix_in_if.sink          i_pix,
    bbl_pix_out_if.source       o_pix
);

    t_cmd    w_cmd;
    t_status w_status;
    t_pixel  w_in_px;
    t_pixel  w_res;
    logic    w_in_ready;

    assign w_in_px.red   = i_pix.red_in;
    assign w_in_px.green = i_pix.green_in;
    assign w_in_px.blue  = i_pix.blue_in;
    assign i_pix.ready   = w_in_ready;

    bbl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bbl_datapath #(
        .RING_DEPTH      (RING_DEPTH),
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (w_in_px),
        .i_pix_end   (i_pix.line_end_in),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_res_ready (o_pix.ready),
        .o_res_valid (o_pix.valid),
        .o_res       (w_res),
        .o_res_end   (o_pix.line_end_out)
    );

    assign o_pix.red_out   = w_res.red;
    assign o_pix.green_out = w_res.green;
    assign o_pix.blue_out  = w_res.blue;

endmodule
